// ----- rtl/core/dqp_pkg.sv -----
// ----------------------------------------------------------------------------
// dqp_pkg
// types and constants shared by the dns query parser modules
// ----------------------------------------------------------------------------
package dqp_pkg;

    typedef enum logic [1:0] {
        PH_HEADER    = 2'd0,
        PH_NAME      = 2'd1,
        PH_TYPECLASS = 2'd2,
        PH_IGNORE    = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_CHAR   = 2'd1,
        KIND_QDONE  = 2'd2,
        KIND_STATUS = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_MORE     = 3'd0,
        ST_DONE     = 3'd1,
        ST_ANSWERS  = 3'd2,
        ST_BAD_NAME = 3'd3,
        ST_SHORT    = 3'd4
    } t_status;

    // work handed from the front to the back
    typedef enum logic [2:0] {
        OP_HDR_STORE = 3'd0,
        OP_HDR_EMIT  = 3'd1,
        OP_CHAR      = 3'd2,
        OP_TC_STORE  = 3'd3,
        OP_TC_EMIT   = 3'd4,
        OP_STATUS    = 3'd5
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        t_status    status;
    } t_cmd;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [7:0]  name_char;
        logic        is_response;
        logic [3:0]  opcode_field;
        logic        authoritative;
        logic        truncated;
        logic        recursion_desired;
        logic        recursion_available;
        logic [3:0]  response_code;
        t_status     status;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    // header and type/class byte positions
    localparam logic [3:0] HDR_QD_HI    = 4'd4;
    localparam logic [3:0] HDR_QD_LO    = 4'd5;
    localparam logic [3:0] HDR_KEEP_END = 4'd6;
    localparam logic [3:0] HDR_CNT_END  = 4'd10;
    localparam logic [3:0] HDR_LAST     = 4'd11;
    localparam logic [3:0] TC_LAST      = 4'd3;

    localparam logic [7:0] MAX_LABEL = 8'd63;
    localparam logic [7:0] DOT_CHAR  = 8'h2E;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

endpackage

// ----- rtl/core/dqp_stream_if.sv -----
// ----------------------------------------------------------------------------
// dqp_stream_if
// valid/ready channels for message bytes in and parse results out
// ----------------------------------------------------------------------------
interface dqp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dqp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [7:0]  name_char;
    logic        is_response;
    logic [3:0]  opcode_field;
    logic        authoritative;
    logic        truncated;
    logic        recursion_desired;
    logic        recursion_available;
    logic [3:0]  response_code;
    logic [2:0]  status;

    modport source (
        output valid, output kind, output word_a, output word_b, output name_char,
        output is_response, output opcode_field, output authoritative,
        output truncated, output recursion_desired, output recursion_available,
        output response_code, output status, input ready
    );
    modport sink (
        input valid, input kind, input word_a, input word_b, input name_char,
        input is_response, input opcode_field, input authoritative,
        input truncated, input recursion_desired, input recursion_available,
        input response_code, input status, output ready
    );
endinterface

// ----- rtl/core/dns_query_stream_parser_unit.sv -----
// ----------------------------------------------------------------------------
// dns_query_stream_parser_unit
// one message byte per cycle in while the command queue is not full; each result
// beat is registered through the command queue and then the output register.
// throughput is one byte per cycle, set by the front parser and the
// four-entry command queue that keeps it running while the output stalls, until it fills.
// synchronous active-low reset clears parser position, queue and output valid.
// ----------------------------------------------------------------------------
module dns_query_stream_parser_unit #(
    parameter int MAX_NAME = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dqp_byte_if.sink      i_in,
    dqp_result_if.source  o_out
);

    dqp_pkg::t_cmd        front_cmd;
    dqp_pkg::t_cmd        queue_cmd;
    dqp_pkg::t_queue_stat qstat;
    logic                 push;
    logic                 pop;

    dqp_front #(
        .MAX_NAME (MAX_NAME)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (qstat),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    dqp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_stat  (qstat)
    );

    dqp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (queue_cmd),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ----- rtl/core/dqp_front.sv -----
// ----------------------------------------------------------------------------
// dqp_front
// tracks message position and classifies each byte into a back-end command
// ----------------------------------------------------------------------------
module dqp_front #(
    parameter int MAX_NAME = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    dqp_byte_if.sink            i_in,
    input  dqp_pkg::t_queue_stat i_qstat,
    output logic                o_push,
    output dqp_pkg::t_cmd       o_cmd
);

    localparam int NW = $clog2(MAX_NAME);
    localparam logic [NW-1:0] NAME_LIMIT = NW'(MAX_NAME - 2);

    dqp_pkg::t_phase r_phase, n_phase;
    logic [3:0]      r_cnt, n_cnt;
    logic [15:0]     r_qd, n_qd;
    logic            r_ans_nz, n_ans_nz;
    logic [15:0]     r_q_left, n_q_left;
    logic [5:0]      r_label_left, n_label_left;
    logic [NW-1:0]   r_name_len, n_name_len;

    logic        accept;
    logic [7:0]  b;
    logic        last;
    logic        bad;
    logic [15:0] q_dec;

    assign i_in.ready = !i_qstat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;
    assign last       = i_in.last_byte;
    assign q_dec      = r_q_left - 16'd1;

    always_comb begin
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_qd         = r_qd;
        n_ans_nz     = r_ans_nz;
        n_q_left     = r_q_left;
        n_label_left = r_label_left;
        n_name_len   = r_name_len;
        o_push       = 1'b0;
        o_cmd.op     = dqp_pkg::OP_STATUS;
        o_cmd.data   = b;
        o_cmd.status = dqp_pkg::ST_MORE;
        bad          = 1'b0;
        if (accept) begin
            case (r_phase)
                dqp_pkg::PH_HEADER: begin
                    if (r_cnt >= dqp_pkg::HDR_LAST) begin
                        o_push   = 1'b1;
                        o_cmd.op = dqp_pkg::OP_HDR_EMIT;
                        if (r_ans_nz) begin
                            o_cmd.status = dqp_pkg::ST_ANSWERS;
                            n_phase      = dqp_pkg::PH_IGNORE;
                        end else if (r_qd == 16'd0) begin
                            o_cmd.status = dqp_pkg::ST_DONE;
                            n_phase      = dqp_pkg::PH_IGNORE;
                        end else begin
                            o_cmd.status = last ? dqp_pkg::ST_SHORT : dqp_pkg::ST_MORE;
                            n_q_left     = r_qd;
                            n_phase      = dqp_pkg::PH_NAME;
                            n_label_left = '0;
                            n_name_len   = '0;
                        end
                    end else begin
                        n_cnt = r_cnt + 4'd1;
                        if (r_cnt < dqp_pkg::HDR_KEEP_END) begin
                            o_push   = 1'b1;
                            o_cmd.op = dqp_pkg::OP_HDR_STORE;
                        end
                        if (r_cnt == dqp_pkg::HDR_QD_HI || r_cnt == dqp_pkg::HDR_QD_LO) begin
                            n_qd = {r_qd[7:0], b};
                        end
                        // answer and authority counts only need a nonzero flag
                        if (r_cnt >= dqp_pkg::HDR_KEEP_END && r_cnt < dqp_pkg::HDR_CNT_END) begin
                            n_ans_nz = r_ans_nz || (b != 8'd0);
                        end
                        if (last) begin
                            o_push       = 1'b1;
                            o_cmd.op     = dqp_pkg::OP_STATUS;
                            o_cmd.status = dqp_pkg::ST_SHORT;
                        end
                    end
                end
                dqp_pkg::PH_NAME: begin
                    if (r_label_left == 6'd0) begin
                        if (b == 8'd0) begin
                            n_phase = dqp_pkg::PH_TYPECLASS;
                            n_cnt   = 4'd0;
                        end else if (b > dqp_pkg::MAX_LABEL) begin
                            bad = 1'b1;
                        end else if (r_name_len != '0) begin
                            if (r_name_len >= NAME_LIMIT) begin
                                bad = 1'b1;
                            end else begin
                                n_label_left = b[5:0];
                                n_name_len   = r_name_len + NW'(1);
                                o_push       = 1'b1;
                                o_cmd.op     = dqp_pkg::OP_CHAR;
                                o_cmd.data   = dqp_pkg::DOT_CHAR;
                            end
                        end else begin
                            n_label_left = b[5:0];
                        end
                    end else begin
                        if (r_name_len >= NAME_LIMIT) begin
                            bad = 1'b1;
                        end else begin
                            n_label_left = r_label_left - 6'd1;
                            n_name_len   = r_name_len + NW'(1);
                            o_push       = 1'b1;
                            o_cmd.op     = dqp_pkg::OP_CHAR;
                        end
                    end
                    if (bad) begin
                        o_push       = 1'b1;
                        o_cmd.op     = dqp_pkg::OP_STATUS;
                        o_cmd.status = dqp_pkg::ST_BAD_NAME;
                        n_phase      = dqp_pkg::PH_IGNORE;
                    end else if (last) begin
                        if (!o_push) begin
                            o_cmd.op = dqp_pkg::OP_STATUS;
                        end
                        o_push       = 1'b1;
                        o_cmd.status = dqp_pkg::ST_SHORT;
                    end
                end
                dqp_pkg::PH_TYPECLASS: begin
                    o_push = 1'b1;
                    if (r_cnt >= dqp_pkg::TC_LAST) begin
                        o_cmd.op = dqp_pkg::OP_TC_EMIT;
                        n_q_left = q_dec;
                        if (q_dec == 16'd0) begin
                            o_cmd.status = dqp_pkg::ST_DONE;
                            n_phase      = dqp_pkg::PH_IGNORE;
                        end else begin
                            o_cmd.status = last ? dqp_pkg::ST_SHORT : dqp_pkg::ST_MORE;
                            n_phase      = dqp_pkg::PH_NAME;
                            n_label_left = '0;
                            n_name_len   = '0;
                        end
                    end else begin
                        n_cnt    = r_cnt + 4'd1;
                        o_cmd.op = dqp_pkg::OP_TC_STORE;
                        if (last) begin
                            o_cmd.op     = dqp_pkg::OP_STATUS;
                            o_cmd.status = dqp_pkg::ST_SHORT;
                        end
                    end
                end
                default: ;
            endcase
            if (last) begin
                n_phase      = dqp_pkg::PH_HEADER;
                n_cnt        = 4'd0;
                n_qd         = 16'd0;
                n_ans_nz     = 1'b0;
                n_q_left     = 16'd0;
                n_label_left = 6'd0;
                n_name_len   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= dqp_pkg::PH_HEADER;
            r_cnt        <= 4'd0;
            r_qd         <= 16'd0;
            r_ans_nz     <= 1'b0;
            r_q_left     <= 16'd0;
            r_label_left <= 6'd0;
            r_name_len   <= '0;
        end else begin
            r_phase      <= n_phase;
            r_cnt        <= n_cnt;
            r_qd         <= n_qd;
            r_ans_nz     <= n_ans_nz;
            r_q_left     <= n_q_left;
            r_label_left <= n_label_left;
            r_name_len   <= n_name_len;
        end
    end

endmodule

// ----- rtl/core/dqp_queue.sv -----
// ----------------------------------------------------------------------------
// dqp_queue
// short command fifo between the front and the back
// ----------------------------------------------------------------------------
module dqp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  dqp_pkg::t_cmd        i_cmd,
    input  logic                 i_pop,
    output dqp_pkg::t_cmd        o_cmd,
    output dqp_pkg::t_queue_stat o_stat
);

    dqp_pkg::t_cmd               r_mem [dqp_pkg::QUEUE_DEPTH];
    logic [dqp_pkg::QUEUE_AW-1:0] r_wr, r_rd;
    logic [dqp_pkg::QUEUE_AW:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_count == (dqp_pkg::QUEUE_AW + 1)'(dqp_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/core/dqp_back.sv -----
// ----------------------------------------------------------------------------
// dqp_back
// assembles header and type/class words and drives the result register
// ----------------------------------------------------------------------------
module dqp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dqp_pkg::t_cmd        i_cmd,
    input  dqp_pkg::t_queue_stat i_qstat,
    output logic                 o_pop,
    dqp_result_if.source         o_out
);

    logic [47:0]      r_hdr;
    logic [23:0]      r_tc;
    dqp_pkg::t_result r_res, n_res;
    logic             r_valid;

    logic is_store;
    logic emit;

    assign is_store = (i_cmd.op == dqp_pkg::OP_HDR_STORE) || (i_cmd.op == dqp_pkg::OP_TC_STORE);
    // store beats never touch the result register, so they drain under a stall
    assign o_pop    = !i_qstat.empty && (is_store || !r_valid || o_out.ready);
    assign emit     = o_pop && !is_store;

    always_comb begin
        n_res              = '0;
        n_res.kind         = dqp_pkg::KIND_STATUS;
        n_res.status       = i_cmd.status;
        case (i_cmd.op)
            dqp_pkg::OP_HDR_EMIT: begin
                n_res.kind                = dqp_pkg::KIND_HEADER;
                n_res.word_a              = r_hdr[47:32];
                n_res.word_b              = r_hdr[15:0];
                n_res.is_response         = r_hdr[31];
                n_res.opcode_field        = r_hdr[30:27];
                n_res.authoritative       = r_hdr[26];
                n_res.truncated           = r_hdr[25];
                n_res.recursion_desired   = r_hdr[24];
                n_res.recursion_available = r_hdr[23];
                n_res.response_code       = r_hdr[19:16];
            end
            dqp_pkg::OP_CHAR: begin
                n_res.kind      = dqp_pkg::KIND_CHAR;
                n_res.name_char = i_cmd.data;
            end
            dqp_pkg::OP_TC_EMIT: begin
                n_res.kind   = dqp_pkg::KIND_QDONE;
                n_res.word_a = r_tc[23:8];
                n_res.word_b = {r_tc[7:0], i_cmd.data};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.op == dqp_pkg::OP_HDR_STORE) begin
            r_hdr <= {r_hdr[39:0], i_cmd.data};
        end
        if (o_pop && i_cmd.op == dqp_pkg::OP_TC_STORE) begin
            r_tc <= {r_tc[15:0], i_cmd.data};
        end
        if (emit) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (emit) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out.valid               = r_valid;
    assign o_out.kind                = r_res.kind;
    assign o_out.word_a              = r_res.word_a;
    assign o_out.word_b              = r_res.word_b;
    assign o_out.name_char           = r_res.name_char;
    assign o_out.is_response         = r_res.is_response;
    assign o_out.opcode_field        = r_res.opcode_field;
    assign o_out.authoritative       = r_res.authoritative;
    assign o_out.truncated           = r_res.truncated;
    assign o_out.recursion_desired   = r_res.recursion_desired;
    assign o_out.recursion_available = r_res.recursion_available;
    assign o_out.response_code       = r_res.response_code;
    assign o_out.status              = r_res.status;

endmodule
